### hw/rtl/fbq_pkg.sv
// Shared types, codes and defaults of the bounded frame queue.
`default_nettype none
package fbq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_FRAME_WIDTH = 32;

  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 5;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic [REQ_W-1:0] REQ_SUBMIT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONSUME = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ENABLED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL_REJECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SINK_FAILED   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POLICY = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] accepted;
    logic [COUNT_W-1:0] dropped;
    logic [COUNT_W-1:0] rejected;
    logic [COUNT_W-1:0] consumed;
    logic [COUNT_W-1:0] failed;
  } stats_t;

endpackage
`default_nettype wire

### hw/rtl/fbq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fbq_obuf.sv
// Output register with one skid entry for result items.
`default_nettype none
module fbq_obuf #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         skid_full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;

  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= push;
          if (push) begin
            skid_data <= push_data;
          end
        end else begin
          out_valid <= push;
          if (push) begin
            out_data <= push_data;
          end
        end
      end else if (push) begin
        // hold the stalled item, park the new one
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bounded_frame_queue_drop_policy_core.sv
// Bounded frame queue with drop-oldest or reject policy, ring buffer in a frame RAM.
// Results: submit, flush and non-popping requests are pushed to the output buffer on
//   acceptance; a popping consume first does a registered read of the frame RAM (S_READ).
// Throughput: one item per cycle while the skid entry is free, none during S_READ.
// Reset: synchronous, clears queue pointers, counters and configuration to defaults;
//   frame RAM content is not cleared.
`default_nettype none
module bounded_frame_queue_drop_policy_core
  import fbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int FRAME_WIDTH = DEF_FRAME_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [REQ_W-1:0]                   req_type,
  input  logic [FRAME_WIDTH-1:0]             frame_in,
  input  logic                               sink_accepts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [STATUS_W-1:0]                status,
  output logic [FRAME_WIDTH-1:0]             frame_out,
  output logic                               frame_out_valid,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   pending_count,
  output logic [COUNT_W-1:0]                 accepted_count,
  output logic [COUNT_W-1:0]                 dropped_count,
  output logic [COUNT_W-1:0]                 rejected_count,
  output logic [COUNT_W-1:0]                 consumed_count,
  output logic [COUNT_W-1:0]                 failed_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   high_watermark
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = CW + $bits(stats_t) + CW;
  localparam int RW = STATUS_W + FRAME_WIDTH + 1 + LW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t               state, state_next;
  logic                 enabled;
  logic [LIMIT_W-1:0]   queue_limit;
  logic                 full_policy;
  logic [AW-1:0]        head, head_next;
  logic [AW-1:0]        tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        peak, peak_next;
  stats_t               stats, stats_next;
  logic [STATUS_W-1:0]  st;
  logic [STATUS_W-1:0]  hold_status;
  logic [LW-1:0]        hold_lo;
  logic [CW-1:0]        limit_eff;
  logic                 full;
  logic                 accept;
  logic                 pop;
  logic                 wr_en;
  logic                 rd_en;
  logic [FRAME_WIDTH-1:0] rd_data;
  logic                 push;
  logic [RW-1:0]        push_data;
  logic                 skid_full;
  logic [RW-1:0]        out_data;
  stats_t               stats_o;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !skid_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (queue_limit == '0) begin
      limit_eff = CW'(1);
    end else if (32'(queue_limit) > QUEUE_DEPTH) begin
      limit_eff = CW'(QUEUE_DEPTH);
    end else begin
      limit_eff = CW'(queue_limit);
    end
  end

  assign full = count >= limit_eff;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    stats_next = stats;
    st         = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    pop        = 1'b0;
    if (accept) begin
      case (req_type)
        REQ_SUBMIT: begin
          if (!enabled) begin
            st = ST_NOT_ENABLED;
          end else if (full && full_policy) begin
            stats_next.rejected = stats.rejected + 32'd1;
            st = ST_FULL_REJECTED;
          end else begin
            if (full) begin
              head_next = adv(head);
              stats_next.dropped = stats.dropped + 32'd1;
            end else begin
              count_next = count + CW'(1);
            end
            wr_en     = 1'b1;
            tail_next = adv(tail);
            stats_next.accepted = stats.accepted + 32'd1;
          end
        end
        REQ_CONSUME: begin
          if (!enabled) begin
            st = ST_NOT_ENABLED;
          end else if (count == '0) begin
            st = ST_QUEUE_EMPTY;
          end else begin
            rd_en      = 1'b1;
            pop        = 1'b1;
            head_next  = adv(head);
            count_next = count - CW'(1);
            if (sink_accepts) begin
              stats_next.consumed = stats.consumed + 32'd1;
            end else begin
              stats_next.failed = stats.failed + 32'd1;
              st = ST_SINK_FAILED;
            end
          end
        end
        REQ_FLUSH: begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
    peak_next = (count_next > peak) ? count_next : peak;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && pop) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enabled     <= 1'b0;
      queue_limit <= LIMIT_RESET;
      full_policy <= 1'b0;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      peak        <= '0;
      stats       <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      peak  <= peak_next;
      stats <= stats_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED:     enabled     <= cfg_data[0];
          REG_QUEUE_LIMIT: queue_limit <= cfg_data[LIMIT_W-1:0];
          REG_FULL_POLICY: full_policy <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // hold result fields while the popped frame is read
  always_ff @(posedge clk) begin
    if (accept && pop) begin
      hold_status <= st;
      hold_lo     <= {count_next, stats_next, peak_next};
    end
  end

  fbq_ram #(
    .WIDTH (FRAME_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (frame_in),
    .rd_en   (rd_en),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  assign push = (accept && !pop) || (state == S_READ);

  always_comb begin
    if (state == S_READ) begin
      push_data = {hold_status, rd_data, 1'b1, hold_lo};
    end else begin
      push_data = {st, FRAME_WIDTH'(0), 1'b0, count_next, stats_next, peak_next};
    end
  end

  fbq_obuf #(
    .W (RW)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign {status, frame_out, frame_out_valid, pending_count, stats_o, high_watermark} = out_data;
  assign accepted_count = stats_o.accepted;
  assign dropped_count  = stats_o.dropped;
  assign rejected_count = stats_o.rejected;
  assign consumed_count = stats_o.consumed;
  assign failed_count   = stats_o.failed;

endmodule
`default_nettype wire

### hw/rtl/fbq_checker.sv
// Port-level assertions for the bounded frame queue, bound to the top level.
`default_nettype none
module fbq_checker
  import fbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int FRAME_WIDTH = DEF_FRAME_WIDTH
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [STATUS_W-1:0]              status,
  input logic [FRAME_WIDTH-1:0]           frame_out,
  input logic                             frame_out_valid,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] high_watermark
);

  a_watermark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending_count <= high_watermark)
    else $error("pending count above high watermark");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_out_valid |-> (status == ST_OK || status == ST_SINK_FAILED))
    else $error("popped frame with wrong status");

  a_no_pop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_out_valid |-> frame_out == '0)
    else $error("frame_out nonzero without pop");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_out))
    else $error("result item changed while stalled");

endmodule

bind bounded_frame_queue_drop_policy_core fbq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .FRAME_WIDTH (FRAME_WIDTH)
) u_fbq_checker (.*);
`default_nettype wire
